### design/dmbpid_pkg.sv
// Shared types, register codes and constants of the dual-mode boiler PID block.
package dmbpid_pkg;

    localparam int AVG_DEPTH_DEF = 8;

    localparam int SAMPLE_W   = 15;
    localparam int ELAPSED_W  = 8;
    localparam int OUTPUT_W   = 10;
    localparam int GAIN_W     = 16;
    localparam int SETPT_W    = 12;
    localparam int PID_MS_W   = 9;
    localparam int WINDOW_W   = 10;
    localparam int INTEG_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Widest running sum over the largest averaging depth (64 samples).
    localparam int SUM_MAX_W = SAMPLE_W + 6;

    localparam int PID_PERIOD_MS  = 250;
    localparam int WINDOW_MS      = 1000;
    localparam int INTEGRAL_LIMIT = 3200;
    localparam int READY_MARGIN   = 16;
    localparam int OUT_MAX        = 1000;
    // Bias that lifts the most negative sample to zero before the divide.
    localparam int SAMPLE_BIAS    = 4096;
    // Q8.8 gains, integral in 1/64 units, output in 1/16384 of the sum.
    localparam int ACC_FRAC       = 14;

    // Scaled gains: 40*kp, 10*ki, 160*kd.
    localparam int KP40_W  = 22;
    localparam int KI10_W  = 20;
    localparam int KD160_W = 24;
    localparam int ERR_W   = 16;
    localparam int PP_W    = KP40_W + 1 + ERR_W;
    localparam int PI_W    = KI10_W + 1 + INTEG_W;
    localparam int PD_W    = KD160_W + 1 + ERR_W;
    localparam int ACC_W   = PD_W + 1;

    localparam int QUEUE_DEPTH = 4;   // power of two

    localparam logic [CFG_IDX_W-1:0] CFG_KP_BREW        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_BREW        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_BREW        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KP_STEAM       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_STEAM       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_STEAM       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BREW_SETPOINT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEAM_SETPOINT = 3'd7;

    localparam logic [GAIN_W-1:0]  KP_BREW_RST        = 16'd640;
    localparam logic [GAIN_W-1:0]  KI_BREW_RST        = 16'd20;
    localparam logic [GAIN_W-1:0]  KD_BREW_RST        = 16'd3072;
    localparam logic [GAIN_W-1:0]  KP_STEAM_RST       = 16'd512;
    localparam logic [GAIN_W-1:0]  KI_STEAM_RST       = 16'd26;
    localparam logic [GAIN_W-1:0]  KD_STEAM_RST       = 16'd2560;
    localparam logic [SETPT_W-1:0] BREW_SETPOINT_RST  = 12'd1488;
    localparam logic [SETPT_W-1:0] STEAM_SETPOINT_RST = 12'd2160;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] temperature_sample;
        logic                       steam_selected;
        logic [ELAPSED_W-1:0]       elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_temperature;
        logic [OUTPUT_W-1:0]        heater_output;
        logic                       ssr_on;
        logic                       steam_ready;
        logic                       steam_active;
    } t_out_item;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp_brew;
        logic [GAIN_W-1:0]  ki_brew;
        logic [GAIN_W-1:0]  kd_brew;
        logic [GAIN_W-1:0]  steam_kp;
        logic [GAIN_W-1:0]  steam_ki;
        logic [GAIN_W-1:0]  steam_kd;
        logic [SETPT_W-1:0] brew_setpoint;
        logic [SETPT_W-1:0] steam_setpoint;
    } t_cfg;

    // One classified sample handed from the front to the back.
    typedef struct packed {
        logic signed [SUM_MAX_W-1:0] sample_sum;
        logic                        steam_mode;
        logic                        clear_integ;
        logic                        run_pid;
        logic [WINDOW_W-1:0]         window_pos;
    } t_work;

endpackage

### design/dual_mode_boiler_pid_with_ssr_window.sv
// Top level of the dual-mode boiler PID controller with relay time window.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data): one beat per loop
//   sample carrying the temperature in 1/16 C, the steam switch and the
//   milliseconds since the previous beat.
//   Output channel (o_out_valid / i_out_ready / o_out_data): exactly one beat
//   per input beat, in order: moving average, held heater output, relay
//   drive, steam-ready flag and active mode.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data): single-cycle writes of
//   the gains and setpoints; write only while no beat is in flight.
// Throughput: one beat per cycle while the receiver takes results. From input
//   accept to output valid: the accept edge writes the queue, then reciprocal
//   multiply, error and integral stage, PID product stage, output register.
// The front end updates the averaging ring, mode and timers in the accept
//   cycle, so the loop-carried state there closes at the accept edge; the
//   integral, previous temperature and held output close in the back stages.
// Reset (synchronous, active low) clears the ring index, the sum, mode,
//   integral, timers and held output; config registers return to defaults.
//   No clearing pass is needed: a one-bit fill flag masks unwritten slots.
// Receiver stall: the back pipeline holds; the 4-entry queue keeps taking
//   beats until full, then o_in_ready drops.
module dual_mode_boiler_pid_with_ssr_window #(
    parameter int AVG_DEPTH = dmbpid_pkg::AVG_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  dmbpid_pkg::t_in_item                    i_in_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output dmbpid_pkg::t_out_item                   o_out_data,
    input  logic                                    i_cfg_we,
    input  logic [dmbpid_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [dmbpid_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import dmbpid_pkg::*;

    t_cfg  r_cfg;
    t_work w_push_work, w_head_work;
    logic  w_push, w_pop, w_q_full, w_q_empty;

    // Configuration register file. Setpoints keep the low 12 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_brew        <= KP_BREW_RST;
            r_cfg.ki_brew        <= KI_BREW_RST;
            r_cfg.kd_brew        <= KD_BREW_RST;
            r_cfg.steam_kp       <= KP_STEAM_RST;
            r_cfg.steam_ki       <= KI_STEAM_RST;
            r_cfg.steam_kd       <= KD_STEAM_RST;
            r_cfg.brew_setpoint  <= BREW_SETPOINT_RST;
            r_cfg.steam_setpoint <= STEAM_SETPOINT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KP_BREW:        r_cfg.kp_brew        <= i_cfg_data;
                CFG_KI_BREW:        r_cfg.ki_brew        <= i_cfg_data;
                CFG_KD_BREW:        r_cfg.kd_brew        <= i_cfg_data;
                CFG_KP_STEAM:       r_cfg.steam_kp       <= i_cfg_data;
                CFG_KI_STEAM:       r_cfg.steam_ki       <= i_cfg_data;
                CFG_KD_STEAM:       r_cfg.steam_kd       <= i_cfg_data;
                CFG_BREW_SETPOINT:  r_cfg.brew_setpoint  <= i_cfg_data[SETPT_W-1:0];
                CFG_STEAM_SETPOINT: r_cfg.steam_setpoint <= i_cfg_data[SETPT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Classify each beat: ring update, mode change, PID tick, window step.
    dmbpid_front #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_work     (w_push_work)
    );

    // Absorb output stalls so the front keeps taking beats.
    dmbpid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_work),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_data  (w_head_work)
    );

    // Average, PID and relay compare; holds as a whole when the sink stalls.
    dmbpid_back #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (w_q_empty),
        .i_work      (w_head_work),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### design/dmbpid_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dmbpid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/dmbpid_front.sv
// Front end: accepts samples, keeps the moving-average ring, mode and timers.
module dmbpid_front #(
    parameter int AVG_DEPTH = dmbpid_pkg::AVG_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dmbpid_pkg::t_in_item i_in_data,
    input  logic                 i_q_full,
    output logic                 o_push,
    output dmbpid_pkg::t_work    o_work
);
    import dmbpid_pkg::*;

    localparam int IW    = $clog2(AVG_DEPTH);
    localparam int SUM_W = SAMPLE_W + IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(AVG_DEPTH - 1);

    logic [IW-1:0]              r_idx, n_idx;
    logic                       r_full, n_full;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic                       r_mode;
    logic [PID_MS_W-1:0]        r_pid_ms, n_pid_ms;
    logic [WINDOW_W-1:0]        r_win, n_win;
    logic                       w_accept;
    logic                       w_run;
    logic [PID_MS_W-1:0]        w_pid_sum;
    logic [WINDOW_W:0]          w_win_sum;
    logic [SAMPLE_W-1:0]        w_rd_data;
    logic signed [SAMPLE_W-1:0] w_old;

    assign w_accept   = i_in_valid && !i_q_full;
    assign o_in_ready = !i_q_full;

    // Slot under the index was never written until the ring has wrapped once.
    assign w_old = r_full ? signed'(w_rd_data) : '0;

    always_comb begin
        n_idx  = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
        n_full = r_full || (r_idx == LAST_IDX);
        n_sum  = r_sum + SUM_W'(i_in_data.temperature_sample) - SUM_W'(w_old);

        w_pid_sum = r_pid_ms + PID_MS_W'(i_in_data.elapsed_ms);
        w_run     = (w_pid_sum > PID_MS_W'(PID_PERIOD_MS));
        n_pid_ms  = w_run ? '0 : w_pid_sum;

        w_win_sum = (WINDOW_W + 1)'(r_win) + (WINDOW_W + 1)'(i_in_data.elapsed_ms);
        if (w_win_sum >= (WINDOW_W + 1)'(WINDOW_MS)) begin
            n_win = WINDOW_W'(w_win_sum - (WINDOW_W + 1)'(WINDOW_MS));
        end else begin
            n_win = WINDOW_W'(w_win_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_full   <= 1'b0;
            r_sum    <= '0;
            r_mode   <= 1'b0;
            r_pid_ms <= '0;
            r_win    <= '0;
        end else if (w_accept) begin
            r_idx    <= n_idx;
            r_full   <= n_full;
            r_sum    <= n_sum;
            r_mode   <= i_in_data.steam_selected;
            r_pid_ms <= n_pid_ms;
            r_win    <= n_win;
        end
    end

    // Prefetch the slot that the next sample will replace.
    dmbpid_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (AVG_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_idx),
        .i_wdata (i_in_data.temperature_sample),
        .i_raddr (w_accept ? n_idx : r_idx),
        .o_rdata (w_rd_data)
    );

    assign o_push = w_accept;

    always_comb begin
        o_work.sample_sum  = SUM_MAX_W'(n_sum);
        o_work.steam_mode  = i_in_data.steam_selected;
        o_work.clear_integ = (i_in_data.steam_selected != r_mode);
        o_work.run_pid     = w_run;
        o_work.window_pos  = n_win;
    end

endmodule

### design/dmbpid_queue.sv
// Small FIFO that decouples the front end from the PID back end.
module dmbpid_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dmbpid_pkg::t_work i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output dmbpid_pkg::t_work o_data
);
    import dmbpid_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_work         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [PW:0]   r_count;
    logic          w_push, w_pop;

    assign o_full  = (r_count == (PW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers wrap on their own since the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/dmbpid_back.sv
// Back end: average divide, PID terms, output clamp and relay window compare.
module dmbpid_back #(
    parameter int AVG_DEPTH = dmbpid_pkg::AVG_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dmbpid_pkg::t_cfg      i_cfg,
    input  logic                  i_q_empty,
    input  dmbpid_pkg::t_work     i_work,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output dmbpid_pkg::t_out_item o_out_data
);
    import dmbpid_pkg::*;

    // Divide by AVG_DEPTH as multiply by a rounded-up reciprocal: exact for
    // every biased sum below 2**UW.
    localparam int UW  = $clog2(AVG_DEPTH * (SAMPLE_BIAS + 16384));
    localparam int L   = $clog2(AVG_DEPTH);
    localparam int SH  = UW + L;
    localparam int PW  = 2 * UW + 1;
    localparam int SW1 = SUM_MAX_W + 1;
    localparam longint RECIP = ((longint'(1) << SH) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam logic [UW:0] RECIP_C = (UW + 1)'(RECIP);
    localparam int QW  = ACC_W - ACC_FRAC;

    logic w_en;

    // Stage 1: biased sum times reciprocal.
    logic                r_s1_v;
    logic [PW-1:0]       r_s1_prod;
    logic                r_s1_mode, r_s1_clear, r_s1_run;
    logic [WINDOW_W-1:0] r_s1_win;
    logic signed [SW1-1:0] w_biased;
    logic [UW-1:0]       w_u;

    // Stage 2: error terms, integral, scaled gains.
    logic                       r_s2_v;
    logic signed [SAMPLE_W-1:0] r_s2_filt;
    logic                       r_s2_ready, r_s2_mode, r_s2_run;
    logic [WINDOW_W-1:0]        r_s2_win;
    logic signed [ERR_W-1:0]    r_s2_err, r_s2_dtemp;
    logic signed [INTEG_W-1:0]  r_s2_integ;
    logic [KP40_W-1:0]          r_s2_kp40;
    logic [KI10_W-1:0]          r_s2_ki10;
    logic [KD160_W-1:0]         r_s2_kd160;

    logic signed [INTEG_W-1:0]  r_integ, n_integ;
    logic signed [SAMPLE_W-1:0] r_prev;

    logic [SAMPLE_W-1:0]        w_q;
    logic signed [SAMPLE_W:0]   w_filt_x;
    logic signed [SAMPLE_W-1:0] w_filt;
    logic [SETPT_W-1:0]         w_setpt;
    logic signed [ERR_W-1:0]    w_setpt_s, w_err, w_dtemp;
    logic                       w_ready;
    logic signed [INTEG_W-1:0]  w_base;
    logic signed [ERR_W:0]      w_isum;
    logic [GAIN_W-1:0]          w_kp, w_ki, w_kd;

    // Stage 3: three products.
    logic                       r_s3_v;
    logic signed [SAMPLE_W-1:0] r_s3_filt;
    logic                       r_s3_ready, r_s3_mode, r_s3_run;
    logic [WINDOW_W-1:0]        r_s3_win;
    logic signed [PP_W-1:0]     r_s3_pp;
    logic signed [PI_W-1:0]     r_s3_pi;
    logic signed [PD_W-1:0]     r_s3_pd;

    // Stage 4: output register.
    logic                  r_ov;
    t_out_item             r_out;
    logic [OUTPUT_W-1:0]   r_held, w_held_next, w_clamped;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [QW-1:0]  w_qacc;

    assign w_en  = !r_ov || i_out_ready;
    assign o_pop = w_en && !i_q_empty;

    // ---- stage 1
    assign w_biased = SW1'(i_work.sample_sum) + SW1'(AVG_DEPTH * SAMPLE_BIAS);
    assign w_u      = UW'(w_biased);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_prod  <= PW'(w_u) * PW'(RECIP_C);
            r_s1_mode  <= i_work.steam_mode;
            r_s1_clear <= i_work.clear_integ;
            r_s1_run   <= i_work.run_pid;
            r_s1_win   <= i_work.window_pos;
        end
    end

    // ---- stage 2
    always_comb begin
        w_q      = SAMPLE_W'(r_s1_prod >> SH);
        w_filt_x = signed'({1'b0, w_q}) - (SAMPLE_W + 1)'(SAMPLE_BIAS);
        w_filt   = w_filt_x[SAMPLE_W-1:0];

        w_setpt   = r_s1_mode ? i_cfg.steam_setpoint : i_cfg.brew_setpoint;
        w_setpt_s = signed'(ERR_W'(w_setpt));
        w_err     = w_setpt_s - ERR_W'(w_filt);
        w_dtemp   = ERR_W'(w_filt) - ERR_W'(r_prev);
        w_ready   = r_s1_mode
                 && (ERR_W'(w_filt) >= w_setpt_s - ERR_W'(READY_MARGIN));

        w_base = r_s1_clear ? '0 : r_integ;
        w_isum = (ERR_W + 1)'(w_base) + (ERR_W + 1)'(w_err);
        if (!r_s1_run) begin
            n_integ = w_base;
        end else if (w_isum > (ERR_W + 1)'(INTEGRAL_LIMIT)) begin
            n_integ = INTEG_W'(INTEGRAL_LIMIT);
        end else if (w_isum < -(ERR_W + 1)'(INTEGRAL_LIMIT)) begin
            n_integ = -INTEG_W'(INTEGRAL_LIMIT);
        end else begin
            n_integ = INTEG_W'(w_isum);
        end

        w_kp = r_s1_mode ? i_cfg.steam_kp : i_cfg.kp_brew;
        w_ki = r_s1_mode ? i_cfg.steam_ki : i_cfg.ki_brew;
        w_kd = r_s1_mode ? i_cfg.steam_kd : i_cfg.kd_brew;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_filt  <= w_filt;
            r_s2_ready <= w_ready;
            r_s2_mode  <= r_s1_mode;
            r_s2_run   <= r_s1_run;
            r_s2_win   <= r_s1_win;
            r_s2_err   <= w_err;
            r_s2_dtemp <= w_dtemp;
            r_s2_integ <= n_integ;
            r_s2_kp40  <= (KP40_W'(w_kp) << 5) + (KP40_W'(w_kp) << 3);
            r_s2_ki10  <= (KI10_W'(w_ki) << 3) + (KI10_W'(w_ki) << 1);
            r_s2_kd160 <= (KD160_W'(w_kd) << 7) + (KD160_W'(w_kd) << 5);
        end
    end

    // Integral and previous temperature advance in item order at stage 2.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (w_en && r_s1_v) begin
            r_integ <= n_integ;
            if (r_s1_run) begin
                r_prev <= w_filt;
            end
        end
    end

    // ---- stage 3
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_filt  <= r_s2_filt;
            r_s3_ready <= r_s2_ready;
            r_s3_mode  <= r_s2_mode;
            r_s3_run   <= r_s2_run;
            r_s3_win   <= r_s2_win;
            r_s3_pp    <= signed'({1'b0, r_s2_kp40}) * r_s2_err;
            r_s3_pi    <= signed'({1'b0, r_s2_ki10}) * r_s2_integ;
            r_s3_pd    <= signed'({1'b0, r_s2_kd160}) * r_s2_dtemp;
        end
    end

    // ---- stage 4
    always_comb begin
        w_acc  = ACC_W'(r_s3_pp) + ACC_W'(r_s3_pi) - ACC_W'(r_s3_pd);
        w_qacc = QW'(w_acc >>> ACC_FRAC);
        if (w_qacc < 0) begin
            w_clamped = '0;
        end else if (w_qacc > QW'(OUT_MAX)) begin
            w_clamped = OUTPUT_W'(OUT_MAX);
        end else begin
            w_clamped = OUTPUT_W'(w_qacc);
        end
        w_held_next = r_s3_run ? w_clamped : r_held;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.filtered_temperature <= r_s3_filt;
            r_out.heater_output        <= w_held_next;
            r_out.ssr_on               <= (r_s3_win < w_held_next);
            r_out.steam_ready          <= r_s3_ready;
            r_out.steam_active         <= r_s3_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_ov   <= 1'b0;
            r_held <= '0;
        end else if (w_en) begin
            r_s1_v <= o_pop;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_ov   <= r_s3_v;
            if (r_s3_v) begin
                r_held <= w_held_next;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

### design/dmbpid_checker.sv
// Port-level checker for the boiler PID block and its bind statement.
module dmbpid_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input dmbpid_pkg::t_out_item i_out_data
);
    import dmbpid_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_output_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.heater_output <= OUTPUT_W'(OUT_MAX)))
        else $error("heater output above full scale");

    a_ssr_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.ssr_on) |-> (i_out_data.heater_output != '0))
        else $error("relay on with zero output");

    a_ready_needs_steam: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.steam_ready) |-> i_out_data.steam_active)
        else $error("steam ready outside steam mode");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled output beat changed");

endmodule

bind dual_mode_boiler_pid_with_ssr_window dmbpid_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the dual-mode boiler PID controller with relay window.
module tb_top;
    import dmbpid_pkg::*;

    localparam int AVG_DEPTH   = AVG_DEPTH_DEF;
    localparam int KP_SCALE    = 40;
    localparam int KI_SCALE    = 10;
    localparam int KD_SCALE    = 160;
    localparam int SAMPLE_MIN  = -4096;
    localparam int SAMPLE_MAX  = 16383;
    localparam int LONG_HOLD   = 64;      // receiver hold-off, well past queue plus pipe
    localparam int DRAIN_TAIL  = 12;      // cycles to idle after the last result
    localparam int MAX_PRINTS  = 40;
    localparam int PHASE_BEATS = 50;
    localparam int RAND_PHASES = 8;
    localparam realtime LIMIT_NS = 5_000_000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    dual_mode_boiler_pid_with_ssr_window #(
        .AVG_DEPTH(AVG_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Controller shadow: register file and loop state, advanced once per
    // accepted sample beat.
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] ctl_reg [8];
    int     avg_ring [AVG_DEPTH];
    int     ring_pos      = 0;
    longint ring_sum      = 0;
    bit     steam_now     = 1'b0;
    int     integ_acc     = 0;
    int     prev_filtered = 0;
    int     held_duty     = 0;
    int     pid_ms        = 0;
    int     window_ms     = 0;

    t_in_item  pending_samples [$];
    t_out_item expected_results [$];
    t_out_item expected_head;
    int  items_queued   = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    bit  in_beat_taken  = 1'b0;
    bit  gaps_on        = 1'b1;
    int  hold_seq       = 0;
    int  hold_seen      = 0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    int  walk_temp      = 1488;
    bit  walk_steam     = 1'b0;

    // Quotient rounded toward minus infinity.
    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        return q;
    endfunction

    function automatic t_out_item boiler_step(t_in_item s);
        t_out_item r;
        int     smp;
        int     setpt;
        int     filt;
        int     err;
        int     dtemp;
        longint kp;
        longint ki;
        longint kd;
        longint accum;
        longint duty;
        smp = int'($signed(s.temperature_sample));
        // A switch flip changes mode and throws away the integral.
        if (s.steam_selected != steam_now) begin
            steam_now = s.steam_selected;
            integ_acc = 0;
        end
        setpt = steam_now ? int'(ctl_reg[CFG_STEAM_SETPOINT])
                          : int'(ctl_reg[CFG_BREW_SETPOINT]);
        // Slide the average; slots not yet written hold zero.
        ring_sum += smp - avg_ring[ring_pos];
        avg_ring[ring_pos] = smp;
        ring_pos = (ring_pos + 1) % AVG_DEPTH;
        filt = int'(floor_quot(ring_sum, AVG_DEPTH));

        pid_ms += int'(s.elapsed_ms);
        if (pid_ms > PID_PERIOD_MS) begin
            pid_ms = 0;
            kp = steam_now ? ctl_reg[CFG_KP_STEAM] : ctl_reg[CFG_KP_BREW];
            ki = steam_now ? ctl_reg[CFG_KI_STEAM] : ctl_reg[CFG_KI_BREW];
            kd = steam_now ? ctl_reg[CFG_KD_STEAM] : ctl_reg[CFG_KD_BREW];
            err   = setpt - filt;
            dtemp = filt - prev_filtered;
            integ_acc += err;
            if (integ_acc > INTEGRAL_LIMIT)  integ_acc = INTEGRAL_LIMIT;
            if (integ_acc < -INTEGRAL_LIMIT) integ_acc = -INTEGRAL_LIMIT;
            // Derivative acts on the measurement, not on the error.
            accum = KP_SCALE * kp * err + KI_SCALE * ki * integ_acc
                  - KD_SCALE * kd * dtemp;
            prev_filtered = filt;
            duty = floor_quot(accum, longint'(1) << ACC_FRAC);
            if (duty < 0)       duty = 0;
            if (duty > OUT_MAX) duty = OUT_MAX;
            held_duty = int'(duty);
        end

        window_ms += int'(s.elapsed_ms);
        if (window_ms >= WINDOW_MS) window_ms -= WINDOW_MS;

        r.filtered_temperature = SAMPLE_W'(filt);
        r.heater_output        = OUTPUT_W'(held_duty);
        r.ssr_on               = window_ms < held_duty;
        r.steam_ready          = steam_now && (filt >= setpt - READY_MARGIN);
        r.steam_active         = steam_now;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Mostly zero, sometimes a few cycles, rarely a long gap.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        if (roll < 6) return CFG_DATA_W'($urandom_range(0, 4095));
        return CFG_DATA_W'($urandom());
    endfunction

    // Junk in the top nibble checks that it gets dropped.
    function automatic logic [CFG_DATA_W-1:0] pick_setpoint();
        int roll;
        logic [SETPT_W-1:0] sp;
        roll = $urandom_range(0, 9);
        if (roll == 0)      sp = '0;
        else if (roll == 1) sp = '1;
        else                sp = SETPT_W'($urandom_range(1200, 2600));
        return {4'($urandom()), sp};
    endfunction

    // Write all eight registers on back-to-back cycles; only call when idle.
    task automatic load_regs(input logic [CFG_DATA_W-1:0] vals [8]);
        int i;
        for (i = 0; i < 8; i++) begin
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= vals[i];
            if (CFG_IDX_W'(i) >= CFG_BREW_SETPOINT)
                ctl_reg[i] = vals[i] & CFG_DATA_W'((1 << SETPT_W) - 1);
            else
                ctl_reg[i] = vals[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_beat(input int temp, input bit steam, input int ms);
        t_in_item b;
        b.temperature_sample = SAMPLE_W'(temp);
        b.steam_selected     = steam;
        b.elapsed_ms         = ELAPSED_W'(ms);
        pending_samples.push_back(b);
        items_queued++;
    endtask

    task automatic wait_all_results();
        while (results_seen != items_queued) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sender: hold the beat until taken, then idle or launch the next one.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !in_beat_taken) begin
                // hold payload until the block takes it
            end else if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap--;
            end else if (pending_samples.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_samples.pop_front();
                send_gap   = gaps_on ? pick_gap() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off whenever the stimulus
    // bumps hold_seq.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_seq != hold_seen) begin
                hold_seen  = hold_seq;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && gaps_on) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each input beat, check each output beat in order.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_beat_taken <= 1'b0;
        end else begin
            in_beat_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready)
                expected_results.push_back(boiler_step(i_in_data));
            if (o_out_valid && i_out_ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    flag_mismatch("result beat with nothing expected");
                end else begin
                    expected_head = expected_results.pop_front();
                    if (o_out_data.filtered_temperature !== expected_head.filtered_temperature)
                        flag_mismatch($sformatf("filtered_temperature got %0d want %0d",
                            $signed(o_out_data.filtered_temperature),
                            $signed(expected_head.filtered_temperature)));
                    if (o_out_data.heater_output !== expected_head.heater_output)
                        flag_mismatch($sformatf("heater_output got %0d want %0d",
                            o_out_data.heater_output, expected_head.heater_output));
                    if (o_out_data.ssr_on !== expected_head.ssr_on)
                        flag_mismatch($sformatf("ssr_on got %b want %b",
                            o_out_data.ssr_on, expected_head.ssr_on));
                    if (o_out_data.steam_ready !== expected_head.steam_ready)
                        flag_mismatch($sformatf("steam_ready got %b want %b",
                            o_out_data.steam_ready, expected_head.steam_ready));
                    if (o_out_data.steam_active !== expected_head.steam_active)
                        flag_mismatch($sformatf("steam_active got %b want %b",
                            o_out_data.steam_active, expected_head.steam_active));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed beats at reset values, at full gains and at zero,
    // then random phases with fresh register settings.
    // ------------------------------------------------------------------
    initial begin
        logic [CFG_DATA_W-1:0] vals [8];
        int ph;
        int n;
        int temp;
        int ms;
        int target;
        int roll;

        ctl_reg[CFG_KP_BREW]        = KP_BREW_RST;
        ctl_reg[CFG_KI_BREW]        = KI_BREW_RST;
        ctl_reg[CFG_KD_BREW]        = KD_BREW_RST;
        ctl_reg[CFG_KP_STEAM]       = KP_STEAM_RST;
        ctl_reg[CFG_KI_STEAM]       = KI_STEAM_RST;
        ctl_reg[CFG_KD_STEAM]       = KD_STEAM_RST;
        ctl_reg[CFG_BREW_SETPOINT]  = CFG_DATA_W'(BREW_SETPOINT_RST);
        ctl_reg[CFG_STEAM_SETPOINT] = CFG_DATA_W'(STEAM_SETPOINT_RST);
        foreach (avg_ring[k]) avg_ring[k] = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset gains: negative floor on a half-empty ring, the PID period
        // boundary (250 waits, 251 fires), mode flips both ways, field extremes.
        queue_beat(-1, 1'b0, 0);
        queue_beat(SAMPLE_MIN, 1'b0, 250);
        queue_beat(SAMPLE_MAX, 1'b0, 1);
        queue_beat(0, 1'b1, 255);
        queue_beat(SAMPLE_MAX, 1'b1, 170);
        queue_beat(SAMPLE_MAX, 1'b1, 85);
        queue_beat(SAMPLE_MAX, 1'b1, 255);
        queue_beat(SAMPLE_MAX, 1'b0, 60);
        queue_beat(SAMPLE_MIN, 1'b0, 255);
        queue_beat(10922, 1'b1, 255);
        wait_all_results();

        // Full gains: cold samples pin the output at full scale (relay on all
        // window), then hot ones pull it to zero. Setpoints carry junk bits.
        vals[CFG_KP_BREW]        = '1;
        vals[CFG_KI_BREW]        = '1;
        vals[CFG_KD_BREW]        = '1;
        vals[CFG_KP_STEAM]       = '1;
        vals[CFG_KI_STEAM]       = '1;
        vals[CFG_KD_STEAM]       = '1;
        vals[CFG_BREW_SETPOINT]  = 16'hF5D0;
        vals[CFG_STEAM_SETPOINT] = 16'hFFFF;
        load_regs(vals);
        for (n = 0; n < 4; n++) queue_beat(0, 1'b0, 255);
        for (n = 0; n < 4; n++) queue_beat(SAMPLE_MAX, 1'b0, 255);
        queue_beat(SAMPLE_MAX, 1'b1, 255);
        wait_all_results();

        // All zero: no drive at all, and a steam-ready threshold below zero.
        foreach (vals[k]) vals[k] = '0;
        load_regs(vals);
        queue_beat(SAMPLE_MIN, 1'b1, 10);
        queue_beat(-128, 1'b1, 251);
        queue_beat(0, 1'b1, 200);
        queue_beat(0, 1'b0, 255);
        wait_all_results();

        // Random phases: mostly a temperature drifting around the active
        // setpoint, some wild samples, an occasional switch flip.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            vals[CFG_KP_BREW]        = pick_gain();
            vals[CFG_KI_BREW]        = pick_gain();
            vals[CFG_KD_BREW]        = pick_gain();
            vals[CFG_KP_STEAM]       = pick_gain();
            vals[CFG_KI_STEAM]       = pick_gain();
            vals[CFG_KD_STEAM]       = pick_gain();
            vals[CFG_BREW_SETPOINT]  = pick_setpoint();
            vals[CFG_STEAM_SETPOINT] = pick_setpoint();
            load_regs(vals);
            gaps_on = (ph != 3);
            for (n = 0; n < PHASE_BEATS; n++) begin
                if ($urandom_range(0, 19) == 0) walk_steam = !walk_steam;
                target = walk_steam ? int'(ctl_reg[CFG_STEAM_SETPOINT])
                                    : int'(ctl_reg[CFG_BREW_SETPOINT]);
                if ($urandom_range(0, 4) == 0) begin
                    temp = int'($urandom_range(0, SAMPLE_MAX - SAMPLE_MIN)) + SAMPLE_MIN;
                end else begin
                    walk_temp += int'($urandom_range(0, 48)) - 24
                               + (target > walk_temp ? 6 : -6);
                    if (walk_temp < SAMPLE_MIN) walk_temp = SAMPLE_MIN;
                    if (walk_temp > SAMPLE_MAX) walk_temp = SAMPLE_MAX;
                    temp = walk_temp;
                end
                roll = $urandom_range(0, 99);
                if (roll < 60)      ms = $urandom_range(20, 130);
                else if (roll < 85) ms = $urandom_range(200, 255);
                else                ms = $urandom_range(0, 255);
                queue_beat(temp, walk_steam, ms);
                // Drain mid-phase once with the sender paused.
                if (ph == 4 && n == PHASE_BEATS / 2) wait_all_results();
            end
            // Hold the receiver off while the sender keeps offering beats.
            if (ph == 2 || ph == 6) hold_seq++;
            wait_all_results();
        end
        gaps_on = 1'b1;

        repeat (DRAIN_TAIL) @(negedge i_clk);
        if (expected_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(LIMIT_NS);
        $display("TIMEOUT waiting for result beats");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
design/dmbpid_pkg.sv
design/dmbpid_ram.sv
design/dmbpid_front.sv
design/dmbpid_queue.sv
design/dmbpid_back.sv
design/dual_mode_boiler_pid_with_ssr_window.sv
design/dmbpid_checker.sv
bench/tb_top.sv
